// ===== rtl/core/odometry_motion_sample_macros.svh =====
`ifndef ODOMETRY_MOTION_SAMPLE_MACROS_SVH
`define ODOMETRY_MOTION_SAMPLE_MACROS_SVH

// same-cycle implication, reset disables the check
`define OMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables the check
`define OMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/oms_pkg.sv =====
package oms_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CSTG = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  localparam int VEC_W    = 45;
  localparam int TRANS_W  = 35;
  localparam int RAD_W    = 18;
  localparam int VAR_W    = 52;
  localparam int SQ_IN_W  = VAR_W + 8;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int SD_W     = SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 4;
  localparam int NMAG_W   = 34;
  localparam int LEN_W    = 37;
  localparam int ROT_W    = 47;
  localparam int RZ_W     = 34;
  localparam int LAT      = 2 * CSTG + SQ_STEPS + 13;

  localparam int INV_GAIN_Q16  = 39797;
  localparam int PI_Q16        = 205887;
  localparam int RAD_TO_BAM_Q8 = 2670177;
  localparam int MIN_TRANS_RST = 66;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [2:0] {
    CFG_ROT_ROT     = 3'd0,
    CFG_ROT_TRANS   = 3'd1,
    CFG_TRANS_TRANS = 3'd2,
    CFG_TRANS_ROT   = 3'd3,
    CFG_MIN_TRANS   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic signed [31:0] old_odom_x;
    logic signed [31:0] old_odom_y;
    logic signed [15:0] old_odom_heading;
    logic signed [31:0] new_odom_x;
    logic signed [31:0] new_odom_y;
    logic signed [15:0] new_odom_heading;
    logic signed [15:0] noise_first_turn;
    logic signed [15:0] noise_travel;
    logic signed [15:0] noise_second_turn;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] moved_x;
    logic signed [31:0] moved_y;
    logic signed [15:0] moved_heading;
  } out_item_t;

  // side data through the vectoring section
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        ph;
    logic [15:0]        oh;
    logic [15:0]        dth;
    logic signed [15:0] s1;
    logic signed [15:0] st;
    logic signed [15:0] s2;
  } vctx_t;

  // side data through the noise section
  typedef struct packed {
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic [15:0]          ph;
    logic signed [15:0]   s1;
    logic signed [15:0]   st;
    logic signed [15:0]   s2;
    logic [TRANS_W-1:0]   trans;
    logic [15:0]          rot1;
    logic [15:0]          rot2;
  } mctx_t;

  // side data through the move section
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        hout;
  } pctx_t;

endpackage

// ===== rtl/core/odometry_motion_sample.sv =====
// channel  | handshake                   | payload
// ---------+-----------------------------+-------------------------------
// in       | in_valid_i / in_ready_o     | in_data_i   (in_item_t)
// out      | out_valid_o / out_ready_i   | out_data_o  (out_item_t)
// config   | cfg_we_i, cfg_idx_i         | cfg_wdata_i (16 bit)
//
// one item per cycle while the skid entry is empty; the pipeline is built from
// two CORDIC chains and a 30-step root extraction per noise term
// the output register plus one skid entry decouple the pipeline from out_ready_i;
// the pipeline halts only while the skid entry is full
// reset clears the valid bits, the output side and the gain registers, and loads MIN_TRANS_RST into min_q
`include "odometry_motion_sample_macros.svh"

module odometry_motion_sample
  import oms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] a1_q, a2_q, a3_q, a4_q, min_q;

  logic           pipe_en;
  logic [LAT-1:0] vld_q;

  logic           out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  out_item_t      out_q, out_d, skid_q, skid_d, last_data;

  // stage A
  logic signed [32:0] a_dx_q, a_dy_q;

  // vectoring
  vctx_t              vctx_q [CSTG+2];
  logic signed [VEC_W-1:0] v_x_q [CSTG+1];
  logic signed [VEC_W-1:0] v_y_q [CSTG+1];
  logic [31:0]        v_z_q [CSTG+1];
  logic signed [VEC_W-1:0] v_x0, v_y0;

  // magnitude and bearing
  logic signed [61:0] m_prod_q;
  logic [15:0]        m_ang_q;
  vctx_t              m_ctx_q;
  logic [TRANS_W-1:0] t_trans;
  logic [15:0]        t_rot1;

  mctx_t              mctx_q [SQ_STEPS+6];

  logic [16:0]        r_mag1, r_mag2;
  logic [34:0]        r_p1, r_p2;
  logic [RAD_W-1:0]   r1_q, r2_q;

  logic [33:0]        g_a1r1_q, g_a1r2_q;
  logic [34:0]        g_a4r_q;
  logic [50:0]        g_a2t_q, g_a3t_q;

  logic [REM_W-1:0]   sq_rem_q  [3][SQ_STEPS+1];
  logic [SD_W-1:0]    sq_root_q [3][SQ_STEPS+1];
  logic [SQ_IN_W-1:0] sq_v_q    [3][SQ_STEPS+1];
  logic [VAR_W-1:0]   var_d [3];
  logic signed [15:0] smp [3];

  logic [NMAG_W-1:0]  n_mag_q [3];
  logic               n_neg_q [3];

  logic [15:0]        k_ang1_q, k_ang2_q;
  logic signed [NMAG_W:0] k_nt_q;
  logic [55:0]        k_p1, k_p2;

  logic [15:0]        h_h_q;
  logic signed [LEN_W-1:0] h_len_q;
  logic [15:0]        h_tmp;

  pctx_t              pctx_q [CSTG+4];
  logic signed [ROT_W-1:0] r_x_q [CSTG+1];
  logic signed [ROT_W-1:0] r_y_q [CSTG+1];
  logic signed [RZ_W-1:0]  r_z_q [CSTG+1];
  logic               flip;
  logic [15:0]        hq;
  logic signed [ROT_W-1:0] x0;

  logic signed [63:0] u_px_q, u_py_q;
  logic signed [39:0] o_mx, o_my;
  logic signed [40:0] o_sx, o_sy;
  logic signed [31:0] o_x_q, o_y_q;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v[40:31] == '0 || v[40:31] == '1) begin
      return v[31:0];
    end else if (v[40]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q  <= '0;
      a2_q  <= '0;
      a3_q  <= '0;
      a4_q  <= '0;
      min_q <= 16'(MIN_TRANS_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ROT_ROT:     a1_q  <= cfg_wdata_i;
        CFG_ROT_TRANS:   a2_q  <= cfg_wdata_i;
        CFG_TRANS_TRANS: a3_q  <= cfg_wdata_i;
        CFG_TRANS_ROT:   a4_q  <= cfg_wdata_i;
        CFG_MIN_TRANS:   min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pipe_en    = !skid_vld_q;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage A: odometry differences
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_dx_q <= {in_data_i.new_odom_x[31], in_data_i.new_odom_x}
              - {in_data_i.old_odom_x[31], in_data_i.old_odom_x};
      a_dy_q <= {in_data_i.new_odom_y[31], in_data_i.new_odom_y}
              - {in_data_i.old_odom_y[31], in_data_i.old_odom_y};
      vctx_q[0].px  <= in_data_i.pose_x;
      vctx_q[0].py  <= in_data_i.pose_y;
      vctx_q[0].ph  <= in_data_i.pose_heading;
      vctx_q[0].oh  <= in_data_i.old_odom_heading;
      vctx_q[0].dth <= in_data_i.new_odom_heading - in_data_i.old_odom_heading;
      vctx_q[0].s1  <= in_data_i.noise_first_turn;
      vctx_q[0].st  <= in_data_i.noise_travel;
      vctx_q[0].s2  <= in_data_i.noise_second_turn;
    end
  end

  // vectoring: fold into the right half plane
  assign v_x0 = $signed({{4{a_dx_q[32]}}, a_dx_q, 8'b0});
  assign v_y0 = $signed({{4{a_dy_q[32]}}, a_dy_q, 8'b0});

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (v_x0[VEC_W-1]) begin
        v_x_q[0] <= -v_x0;
        v_y_q[0] <= -v_y0;
        v_z_q[0] <= 32'h8000_0000;
      end else begin
        v_x_q[0] <= v_x0;
        v_y_q[0] <= v_y0;
        v_z_q[0] <= '0;
      end
      vctx_q[1] <= vctx_q[0];
    end
  end

  for (genvar i = 0; i < CSTG; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        if (!v_y_q[i][VEC_W-1] && (v_y_q[i] != '0)) begin
          v_x_q[i+1] <= v_x_q[i] + (v_y_q[i] >>> i);
          v_y_q[i+1] <= v_y_q[i] - (v_x_q[i] >>> i);
          v_z_q[i+1] <= v_z_q[i] + ATAN_TAB[i];
        end else begin
          v_x_q[i+1] <= v_x_q[i] - (v_y_q[i] >>> i);
          v_y_q[i+1] <= v_y_q[i] + (v_x_q[i] >>> i);
          v_z_q[i+1] <= v_z_q[i] - ATAN_TAB[i];
        end
        vctx_q[i+2] <= vctx_q[i+1];
      end
    end
  end

  // gain removal and bearing rounding
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_prod_q <= 62'(v_x_q[CSTG]) * 62'(INV_GAIN_Q16) + 62'(1 << 23);
      m_ang_q  <= 16'((v_z_q[CSTG] + 32'h0000_8000) >> 16);
      m_ctx_q  <= vctx_q[CSTG+1];
    end
  end

  // split into first rotation, translation, second rotation
  assign t_trans = m_prod_q[TRANS_W+23:24];
  assign t_rot1  = (t_trans > TRANS_W'(min_q)) ? (m_ang_q - m_ctx_q.oh) : 16'd0;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mctx_q[0].px    <= m_ctx_q.px;
      mctx_q[0].py    <= m_ctx_q.py;
      mctx_q[0].ph    <= m_ctx_q.ph;
      mctx_q[0].s1    <= m_ctx_q.s1;
      mctx_q[0].st    <= m_ctx_q.st;
      mctx_q[0].s2    <= m_ctx_q.s2;
      mctx_q[0].trans <= t_trans;
      mctx_q[0].rot1  <= t_rot1;
      mctx_q[0].rot2  <= m_ctx_q.dth - t_rot1;
    end
  end

  // angles to Q16.16 radians
  assign r_mag1 = mctx_q[0].rot1[15] ? (17'd0 - {1'b1, mctx_q[0].rot1})
                                     : {1'b0, mctx_q[0].rot1};
  assign r_mag2 = mctx_q[0].rot2[15] ? (17'd0 - {1'b1, mctx_q[0].rot2})
                                     : {1'b0, mctx_q[0].rot2};
  assign r_p1 = 35'(r_mag1) * 35'(PI_Q16) + 35'(1 << 14);
  assign r_p2 = 35'(r_mag2) * 35'(PI_Q16) + 35'(1 << 14);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r1_q      <= r_p1[RAD_W+14:15];
      r2_q      <= r_p2[RAD_W+14:15];
      mctx_q[1] <= mctx_q[0];
    end
  end

  // gain products
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_a1r1_q  <= 34'(a1_q) * 34'(r1_q);
      g_a1r2_q  <= 34'(a1_q) * 34'(r2_q);
      g_a4r_q   <= 35'(a4_q) * 35'(19'(r1_q) + 19'(r2_q));
      g_a2t_q   <= 51'(a2_q) * 51'(mctx_q[1].trans);
      g_a3t_q   <= 51'(a3_q) * 51'(mctx_q[1].trans);
      mctx_q[2] <= mctx_q[1];
    end
  end

  assign var_d[0] = VAR_W'(g_a1r1_q) + VAR_W'(g_a2t_q);
  assign var_d[1] = VAR_W'(g_a3t_q) + VAR_W'(g_a4r_q);
  assign var_d[2] = VAR_W'(g_a1r2_q) + VAR_W'(g_a2t_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mctx_q[3] <= mctx_q[2];
    end
  end

  // square roots, one result bit per stage
  for (genvar u = 0; u < 3; u++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sq_v_q[u][0]    <= {var_d[u], 8'b0};
        sq_rem_q[u][0]  <= '0;
        sq_root_q[u][0] <= '0;
      end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
      logic [REM_W-1:0] rem_sh, trial;

      assign rem_sh = {sq_rem_q[u][j][REM_W-3:0], sq_v_q[u][j][SQ_IN_W-1 -: 2]};
      assign trial  = REM_W'({sq_root_q[u][j], 2'b01});

      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          sq_v_q[u][j+1] <= sq_v_q[u][j] << 2;
          if (rem_sh >= trial) begin
            sq_rem_q[u][j+1]  <= rem_sh - trial;
            sq_root_q[u][j+1] <= {sq_root_q[u][j][SD_W-2:0], 1'b1};
          end else begin
            sq_rem_q[u][j+1]  <= rem_sh;
            sq_root_q[u][j+1] <= {sq_root_q[u][j][SD_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq_ctx
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        mctx_q[j+4] <= mctx_q[j+3];
      end
    end
  end

  // noise magnitudes: std times sample, rounded half away from zero
  assign smp[0] = mctx_q[SQ_STEPS+3].s1;
  assign smp[1] = mctx_q[SQ_STEPS+3].st;
  assign smp[2] = mctx_q[SQ_STEPS+3].s2;

  for (genvar u = 0; u < 3; u++) begin : g_noise
    logic [15:0] s_mag;
    logic [45:0] n_prod;

    assign s_mag  = smp[u][15] ? (16'd0 - smp[u]) : smp[u];
    assign n_prod = 46'(sq_root_q[u][SQ_STEPS]) * 46'(s_mag) + 46'(2048);

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        n_mag_q[u] <= n_prod[45:12];
        n_neg_q[u] <= smp[u][15];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mctx_q[SQ_STEPS+4] <= mctx_q[SQ_STEPS+3];
    end
  end

  // rotation noise to binary angle, translation noise signed
  assign k_p1 = 56'(n_mag_q[0]) * 56'(RAD_TO_BAM_Q8) + 56'(1 << 23);
  assign k_p2 = 56'(n_mag_q[2]) * 56'(RAD_TO_BAM_Q8) + 56'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      k_ang1_q <= n_neg_q[0] ? (16'd0 - k_p1[39:24]) : k_p1[39:24];
      k_ang2_q <= n_neg_q[2] ? (16'd0 - k_p2[39:24]) : k_p2[39:24];
      k_nt_q   <= n_neg_q[1] ? -$signed({1'b0, n_mag_q[1]}) : $signed({1'b0, n_mag_q[1]});
      mctx_q[SQ_STEPS+5] <= mctx_q[SQ_STEPS+4];
    end
  end

  // noisy heading, noisy length and final heading
  assign h_tmp = mctx_q[SQ_STEPS+5].ph + mctx_q[SQ_STEPS+5].rot1 + k_ang1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      h_h_q          <= h_tmp;
      h_len_q        <= $signed({2'b00, mctx_q[SQ_STEPS+5].trans})
                      + LEN_W'(k_nt_q);
      pctx_q[0].px   <= mctx_q[SQ_STEPS+5].px;
      pctx_q[0].py   <= mctx_q[SQ_STEPS+5].py;
      pctx_q[0].hout <= h_tmp + mctx_q[SQ_STEPS+5].rot2 + k_ang2_q;
    end
  end

  // rotation: bring heading into +-quarter turn
  assign flip = ($signed(h_h_q) > 16'sd16384) || ($signed(h_h_q) < -16'sd16384);
  assign hq   = flip ? {~h_h_q[15], h_h_q[14:0]} : h_h_q;
  assign x0   = $signed({{2{h_len_q[LEN_W-1]}}, h_len_q, 8'b0});

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r_x_q[0]  <= flip ? -x0 : x0;
      r_y_q[0]  <= '0;
      r_z_q[0]  <= $signed({{2{hq[15]}}, hq, 16'b0});
      pctx_q[1] <= pctx_q[0];
    end
  end

  for (genvar i = 0; i < CSTG; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        if (!r_z_q[i][RZ_W-1]) begin
          r_x_q[i+1] <= r_x_q[i] - (r_y_q[i] >>> i);
          r_y_q[i+1] <= r_y_q[i] + (r_x_q[i] >>> i);
          r_z_q[i+1] <= r_z_q[i] - $signed({2'b00, ATAN_TAB[i]});
        end else begin
          r_x_q[i+1] <= r_x_q[i] + (r_y_q[i] >>> i);
          r_y_q[i+1] <= r_y_q[i] - (r_x_q[i] >>> i);
          r_z_q[i+1] <= r_z_q[i] + $signed({2'b00, ATAN_TAB[i]});
        end
        pctx_q[i+2] <= pctx_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      u_px_q         <= 64'(r_x_q[CSTG]) * 64'(INV_GAIN_Q16) + 64'(1 << 23);
      u_py_q         <= 64'(r_y_q[CSTG]) * 64'(INV_GAIN_Q16) + 64'(1 << 23);
      pctx_q[CSTG+2] <= pctx_q[CSTG+1];
    end
  end

  assign o_mx = u_px_q[63:24];
  assign o_my = u_py_q[63:24];
  assign o_sx = $signed({{9{pctx_q[CSTG+2].px[31]}}, pctx_q[CSTG+2].px}) + 41'(o_mx);
  assign o_sy = $signed({{9{pctx_q[CSTG+2].py[31]}}, pctx_q[CSTG+2].py}) + 41'(o_my);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      o_x_q          <= sat32(o_sx);
      o_y_q          <= sat32(o_sy);
      pctx_q[CSTG+3] <= pctx_q[CSTG+2];
    end
  end

  assign last_data.moved_x       = o_x_q;
  assign last_data.moved_y       = o_y_q;
  assign last_data.moved_heading = pctx_q[CSTG+3].hout;

  // output register and skid entry
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_d = vld_q[LAT-1];
      out_d     = last_data;
    end else if (vld_q[LAT-1]) begin
      skid_vld_d = 1'b1;
      skid_d     = last_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `OMS_ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni, skid_vld_q, out_vld_q,
    "skid entry holds an item while output register is empty")
  `OMS_ASSERT_NXT(a_blocked_to_skid, clk_i, rst_ni,
    vld_q[LAT-1] && !skid_vld_q && out_vld_q && !out_ready_i, skid_vld_q,
    "item leaving pipeline under back pressure was dropped")
  `OMS_ASSERT_NXT(a_drain_no_skid, clk_i, rst_ni,
    out_vld_q && out_ready_i && !skid_vld_q, !skid_vld_q,
    "skid entry filled while output was being taken")
  `OMS_ASSERT_IMP(a_mag_positive, clk_i, rst_ni, vld_q[CSTG+1],
    !v_x_q[CSTG][VEC_W-1], "vectoring magnitude went negative")

endmodule

// ===== dv/odometry_motion_sample_tb.sv =====
`timescale 1ns / 1ps

module odometry_motion_sample_tb;
  import oms_pkg::*;

  localparam int PIPE_LAT   = LAT;
  localparam int RAND_ITEMS = 550;
  localparam longint MAX_CYCLES = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  odometry_motion_sample dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor copy of the gain registers
  logic [15:0] g_rot_rot, g_rot_trans, g_trans_trans, g_trans_rot, g_min_trans;

  in_item_t  pending_particles[$];
  out_item_t expected_poses[$];

  int  send_idle_pct, recv_idle_pct;
  bit  hold_recv;
  bit  in_taken;
  int  mismatches, poses_checked, particles_sent;
  longint cycle_cnt;

  localparam logic [31:0] ATAN_LUT [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint drop_gain(longint v);
    return (v * 39797 + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint wrap_angle(longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return longint'(w);
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint angle_to_rad(longint a);
    longint unsigned m;
    m = (a < 0) ? -a : a;
    return longint'((m * 205887 + (64'd1 << 14)) >> 15);
  endfunction

  function automatic longint scaled_noise(longint unsigned variance, longint s);
    longint unsigned sd, m;
    longint q;
    sd = root_floor(variance << 8);
    m = (s < 0) ? -s : s;
    q = longint'((sd * m + 2048) >> 12);
    return (s < 0) ? -q : q;
  endfunction

  function automatic longint rad_to_binang(longint r);
    longint unsigned m;
    longint q;
    m = (r < 0) ? -r : r;
    q = longint'((m * 2670177 + (64'd1 << 23)) >> 24);
    return wrap_angle((r < 0) ? -q : q);
  endfunction

  function automatic out_item_t predict_move(in_item_t p);
    longint dx, dy, x, y, t, z, trans, bearing, rot1, rot2, r1, r2;
    longint n1, nt, n2, h, len, mx, my;
    logic [31:0] za;
    out_item_t r;
    // vectoring: magnitude and bearing of the odometry step
    dx = longint'(p.new_odom_x) - longint'(p.old_odom_x);
    dy = longint'(p.new_odom_y) - longint'(p.old_odom_y);
    x = dx * 256;
    y = dy * 256;
    za = 32'd0;
    if (x < 0) begin
      x = -x; y = -y; za = 32'h8000_0000;
    end
    for (int i = 0; i < CSTG; i++) begin
      if (y > 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; za = za + ATAN_LUT[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; za = za - ATAN_LUT[i];
      end
    end
    trans = drop_gain(x);
    bearing = wrap_angle(longint'((64'(za) + 64'h8000) >> 16));
    rot1 = (trans > longint'(g_min_trans)) ?
           wrap_angle(bearing - longint'(p.old_odom_heading)) : 0;
    rot2 = wrap_angle(wrap_angle(longint'(p.new_odom_heading) -
                                 longint'(p.old_odom_heading)) - rot1);
    r1 = angle_to_rad(rot1);
    r2 = angle_to_rad(rot2);
    n1 = rad_to_binang(scaled_noise(g_rot_rot * r1 + g_rot_trans * trans,
                                    p.noise_first_turn));
    nt = scaled_noise(g_trans_trans * trans + g_trans_rot * (r1 + r2), p.noise_travel);
    n2 = rad_to_binang(scaled_noise(g_rot_rot * r2 + g_rot_trans * trans,
                                    p.noise_second_turn));
    h = wrap_angle(longint'(p.pose_heading) + rot1 + n1);
    // rotation mode: fold heading into +-90 degrees first
    len = trans + nt;
    x = len * 256;
    y = 0;
    z = h;
    if (z > 16384) begin
      z = z - 32768; x = -x;
    end else if (z < -16384) begin
      z = z + 32768; x = -x;
    end
    z = z * 65536;
    for (int i = 0; i < CSTG; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - longint'(ATAN_LUT[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + longint'(ATAN_LUT[i]);
      end
    end
    mx = drop_gain(x);
    my = drop_gain(y);
    r.moved_x = 32'(sat_pos(longint'(p.pose_x) + mx));
    r.moved_y = 32'(sat_pos(longint'(p.pose_y) + my));
    r.moved_heading = 16'(wrap_angle(h + rot2 + n2));
    return r;
  endfunction

  // input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        expected_poses.push_back(predict_move(in_data_i));
        particles_sent++;
      end
      if (!in_valid_i || in_taken) begin
        if (pending_particles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= pending_particles.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    cycle_cnt++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", out_data_o);
      end else begin
        want = expected_poses.pop_front();
        poses_checked++;
        if (out_data_o.moved_x !== want.moved_x || out_data_o.moved_y !== want.moved_y ||
            out_data_o.moved_heading !== want.moved_heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at item %0d: expected %p, got %p", poses_checked - 1,
                     want, out_data_o);
        end
      end
    end
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout with %0d items outstanding", expected_poses.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_gain(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROT_ROT:     g_rot_rot = val;
      CFG_ROT_TRANS:   g_rot_trans = val;
      CFG_TRANS_TRANS: g_trans_trans = val;
      CFG_TRANS_ROT:   g_trans_rot = val;
      default:         g_min_trans = val;
    endcase
  endtask

  task automatic set_gains(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                           logic [15:0] a4, logic [15:0] mt);
    write_gain(CFG_ROT_ROT, a1);
    write_gain(CFG_ROT_TRANS, a2);
    write_gain(CFG_TRANS_TRANS, a3);
    write_gain(CFG_TRANS_ROT, a4);
    write_gain(CFG_MIN_TRANS, mt);
  endtask

  task automatic drain_all();
    while (pending_particles.size() > 0 || in_valid_i || expected_poses.size() > 0)
      @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_pos(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // mostly plausible odometry steps, some wild and some full-range
  function automatic in_item_t random_particle();
    in_item_t p;
    int mode;
    logic signed [31:0] step;
    mode = $urandom_range(9);
    p = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()});
    if (mode >= 2) begin
      p.old_odom_x = rand_pos(2);
      p.old_odom_y = rand_pos(2);
      step = (mode == 9) ? 32'sd0 : rand_pos(1);
      p.new_odom_x = p.old_odom_x + step;
      step = (mode == 9) ? 32'sd0 : rand_pos(1);
      p.new_odom_y = p.old_odom_y + step;
      p.pose_x = rand_pos(2);
      p.pose_y = rand_pos(2);
      p.noise_first_turn  = $signed(16'($urandom_range(16384))) - 16'sd8192;
      p.noise_travel      = $signed(16'($urandom_range(16384))) - 16'sd8192;
      p.noise_second_turn = $signed(16'($urandom_range(16384))) - 16'sd8192;
    end
    return p;
  endfunction

  function automatic in_item_t make_particle(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [15:0] ph, logic signed [31:0] ox, logic signed [31:0] oy,
      logic signed [15:0] oh, logic signed [31:0] nx, logic signed [31:0] ny,
      logic signed [15:0] nh, logic signed [15:0] s);
    in_item_t p;
    p = '{px, py, ph, ox, oy, oh, nx, ny, nh, s, s, -s};
    return p;
  endfunction

  initial begin
    localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_ROT_ROT; cfg_wdata_i = '0;
    mismatches = 0; poses_checked = 0; particles_sent = 0; cycle_cnt = 0;
    hold_recv = 1'b0; send_idle_pct = 0; recv_idle_pct = 0;
    g_rot_rot = '0; g_rot_trans = '0; g_trans_trans = '0; g_trans_rot = '0;
    g_min_trans = 16'(MIN_TRANS_RST);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset gains (noise-free)
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 66, 0, 100, 4096));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 67, 0, 100, 4096));
    pending_particles.push_back(make_particle(5, 5, 16'sh7fff, 0, 0, 16'sh8000,
                                              32'sh10000, 32'sh10000, 16'sh7fff, 0));
    pending_particles.push_back(make_particle(PMAX, PMAX, 0, PMIN, PMIN, 0,
                                              PMAX, PMAX, 0, 16'sh7fff));
    pending_particles.push_back(make_particle(PMIN, PMIN, 16'sh8000, PMAX, PMAX, 0,
                                              PMIN, PMIN, 16'sh8000, 16'sh8000));
    pending_particles.push_back(make_particle(PMAX, 0, 16384, PMAX, 0, 0, PMIN, 0,
                                              16384, 0));
    pending_particles.push_back(make_particle(0, 0, -16384, 0, PMIN, 0, 0, PMAX,
                                              -16384, 0));
    drain_all();

    // full gains, noise extremes, backward travel
    set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sh20000, 0, 8000,
                                              16'sh7fff));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sh20000, 0, 8000,
                                              16'sh8000));
    pending_particles.push_back(make_particle(PMAX, PMIN, 16'sh7fff, 0, 0, 16'sh8000,
                                              32'sh7ff0000, 32'sh7ff0000, 16'sh7fff,
                                              16'sh8000));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 32'sh10000, 0, 0, -16384));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 65535, 0, 0, 0));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 65536, 0, 0, 0));
    // long receiver hold while the sender keeps offering
    hold_recv = 1'b1;
    for (int i = 0; i < 150; i++) pending_particles.push_back(random_particle());
    repeat (PIPE_LAT * 3) @(posedge clk_i);
    hold_recv = 1'b0;
    drain_all();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_gains(16'd256, 16'd64, 16'd128, 16'd32, 16'd0);
        1: set_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd66);
        default: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()));
      endcase
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 23 : 0;
      for (int i = 0; i < (RAND_ITEMS - 150) / 3; i++)
        pending_particles.push_back(random_particle());
      drain_all();
    end

    $display("covered %0d particle updates, %0d poses checked over 5 gain settings",
             particles_sent, poses_checked);
    $display("directed extremes, saturation, backward moves and a long output stall");
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_poses.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== odometry_motion_sample.f =====
+incdir+rtl/core
rtl/core/oms_pkg.sv
rtl/core/odometry_motion_sample.sv
dv/odometry_motion_sample_tb.sv
